// File: hw/rtl/mvt_pkg.sv
// shared types and codes for the 4x4 matrix-vector transform
// no dependencies; imported by the top, mvt_matrix and mvt_row
package mvt_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned DIM    = 4;
  localparam int unsigned IDX_W  = 4;

  // action codes carried in the input tuser
  localparam logic ACTION_LOAD  = 1'b0;
  localparam logic ACTION_XFORM = 1'b1;

  typedef logic signed [DATA_W-1:0] elem_t;
  typedef elem_t [DIM-1:0]          vec_t;
  typedef elem_t [DIM*DIM-1:0]      mat_t;

  // per-stage advance enables for the row datapath
  typedef struct packed {
    logic en_mul;
    logic en_add;
    logic en_out;
  } stage_en_t;

endpackage

// File: hw/rtl/matrix_vector_transform_4x4_top.sv
// top level of the 4x4 matrix-vector transform: stream handshake, valid pipeline
// depends on mvt_pkg, mvt_matrix and mvt_row
//
// usage
//   input stream (s_axis): each word is a load or a transform, chosen by tuser
//     load: writes matrix element element_index (row*4+col), gives no output word
//     transform: carries x, y, z, w; gives one output word with the four row
//     dot products in signed fixed point, floored and clipped to 32 bits
//   output stream (m_axis): out_x..out_w in tdata, saturated flag in tuser
//   throughput: one input word per cycle unless stalled, loads and transforms mixed freely
//   order: a transform accepted on s_axis has its products registered at its
//     accept edge, then its pair sums, then the final add and clip into the
//     output register that drives m_axis
//   a load takes effect at its accept edge; any later transform sees it
//   reset: matrix cleared to zero, all stage valid bits cleared, no output word
//   stall: each stage holds while the one after it is full and not moving,
//     so bubbles close up; s_axis_tready drops only when all three stages
//     are full and m_axis_tready is low; nothing is lost or repeated
module matrix_vector_transform_4x4_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [167:0] s_axis_tdata,  // element_index[3:0], element_value[35:4],
                                      // in_x[67:36], in_y[99:68], in_z[131:100],
                                      // in_w[163:132], zero pad[167:164]
  input  logic         s_axis_tuser,  // action
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // out_x[31:0], out_y[63:32], out_z[95:64],
                                      // out_w[127:96]
  output logic         m_axis_tuser   // saturated
);
  import mvt_pkg::*;

  // input field unpacking
  logic [IDX_W-1:0] element_index;
  elem_t            element_value;
  vec_t             vec;

  assign element_index = s_axis_tdata[IDX_W-1:0];
  assign element_value = s_axis_tdata[IDX_W +: DATA_W];
  always_comb begin
    for (int c = 0; c < DIM; c++) begin
      vec[c] = s_axis_tdata[IDX_W + DATA_W*(c+1) +: DATA_W];
    end
  end

  // stage valid bits; v3 is the output register
  logic      v1_q, v2_q, v3_q;
  logic      v1_d, v2_d, v3_d;
  logic      en_mul, en_add, en_out;
  stage_en_t en;
  logic      accept;

  // a stage may load when it is empty or its content moves on this edge
  assign en_out = !v3_q || m_axis_tready;
  assign en_add = !v2_q || en_out;
  assign en_mul = !v1_q || en_add;
  assign en     = '{en_mul: en_mul, en_add: en_add, en_out: en_out};

  assign s_axis_tready = en_mul;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    v1_d = en_mul ? (accept && (s_axis_tuser == ACTION_XFORM)) : v1_q;
    v2_d = en_add ? v1_q : v2_q;
    v3_d = en_out ? v2_q : v3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  // matrix store: written at the accept edge of a load word; a transform
  // multiplies against the store as it stands before its own accept edge
  mat_t mat;

  mvt_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (accept && (s_axis_tuser == ACTION_LOAD)),
    .idx_i   (element_index),
    .value_i (element_value),
    .mat_o   (mat)
  );

  // four row datapaths in parallel
  logic [DIM-1:0] clip;

  for (genvar r = 0; r < DIM; r++) begin : g_row
    vec_t  row;
    elem_t res;

    for (genvar c = 0; c < DIM; c++) begin : g_col
      assign row[c] = mat[r*DIM + c];
    end

    mvt_row #(
      .FRAC_BITS (FRAC_BITS)
    ) u_row (
      .clk_i  (clk_i),
      .row_i  (row),
      .vec_i  (vec),
      .en_i   (en),
      .res_o  (res),
      .clip_o (clip[r])
    );

    assign m_axis_tdata[r*DATA_W +: DATA_W] = res;
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tuser  = |clip;

endmodule

// File: hw/rtl/mvt_matrix.sv
// sixteen-element row-major matrix store, cleared at reset
// depends on mvt_pkg
module mvt_matrix (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      we_i,
  input  logic [mvt_pkg::IDX_W-1:0] idx_i,
  input  mvt_pkg::elem_t            value_i,
  output mvt_pkg::mat_t             mat_o
);
  import mvt_pkg::*;

  mat_t mat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= '0;
    end else if (we_i) begin
      mat_q[idx_i] <= value_i;
    end
  end

  assign mat_o = mat_q;

endmodule

// File: hw/rtl/mvt_row.sv
// one matrix row: four multipliers, two-level adder, floor shift and saturation
// depends on mvt_pkg; three register stages gated by stage_en_t
module mvt_row #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  mvt_pkg::vec_t      row_i,
  input  mvt_pkg::vec_t      vec_i,
  input  mvt_pkg::stage_en_t en_i,
  output mvt_pkg::elem_t     res_o,
  output logic               clip_o
);
  import mvt_pkg::*;

  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned PAIR_W = PROD_W + 1;
  localparam int unsigned SUM_W  = PROD_W + 2;

  localparam logic signed [SUM_W-1:0] MaxV = SUM_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}));
  localparam logic signed [SUM_W-1:0] MinV = -SUM_W'(signed'({1'b0, 1'b1,
                                                              {(DATA_W-1){1'b0}}}));

  logic signed [DATA_W-1:0] m   [DIM];
  logic signed [DATA_W-1:0] v   [DIM];
  logic signed [PROD_W-1:0] p_q [DIM];
  logic signed [PAIR_W-1:0] pair_d [2];
  logic signed [PAIR_W-1:0] pair_q [2];
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  shifted;
  elem_t                    res_d, res_q;
  logic                     clip_d, clip_q;

  always_comb begin
    for (int c = 0; c < DIM; c++) begin
      m[c] = $signed(row_i[c]);
      v[c] = $signed(vec_i[c]);
    end
  end

  // stage 1: products
  always_ff @(posedge clk_i) begin
    if (en_i.en_mul) begin
      for (int c = 0; c < DIM; c++) begin
        p_q[c] <= m[c] * v[c];
      end
    end
  end

  // stage 2: pairwise sums
  assign pair_d[0] = {p_q[0][PROD_W-1], p_q[0]} + {p_q[1][PROD_W-1], p_q[1]};
  assign pair_d[1] = {p_q[2][PROD_W-1], p_q[2]} + {p_q[3][PROD_W-1], p_q[3]};

  always_ff @(posedge clk_i) begin
    if (en_i.en_add) begin
      pair_q <= pair_d;
    end
  end

  // stage 3: final sum, drop fraction bits (floor), clip to 32 bits
  assign sum     = {pair_q[0][PAIR_W-1], pair_q[0]} + {pair_q[1][PAIR_W-1], pair_q[1]};
  assign shifted = sum >>> FRAC_BITS;

  always_comb begin
    if (shifted > MaxV) begin
      res_d  = {1'b0, {(DATA_W-1){1'b1}}};
      clip_d = 1'b1;
    end else if (shifted < MinV) begin
      res_d  = {1'b1, {(DATA_W-1){1'b0}}};
      clip_d = 1'b1;
    end else begin
      res_d  = shifted[DATA_W-1:0];
      clip_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en_out) begin
      res_q  <= res_d;
      clip_q <= clip_d;
    end
  end

  assign res_o  = res_q;
  assign clip_o = clip_q;

endmodule

// File: hw/rtl/mvt_checker.sv
// port-level checks for the 4x4 matrix-vector transform
// depends on nothing; bound to matrix_vector_transform_4x4_top below
module mvt_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic         m_axis_tuser
);

  localparam logic [31:0] PosLimit = 32'h7fff_ffff;
  localparam logic [31:0] NegLimit = 32'h8000_0000;

  // a stalled output word holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // output valid only drops after a completed transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(m_axis_tvalid) |-> $past(m_axis_tready))
    else $error("output word dropped without transfer");

  // input back-pressure only when the output is full and stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with room in the pipeline");

  // saturated flag means at least one component sits at a limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata[31:0]   == PosLimit) || (m_axis_tdata[31:0]   == NegLimit) ||
      (m_axis_tdata[63:32]  == PosLimit) || (m_axis_tdata[63:32]  == NegLimit) ||
      (m_axis_tdata[95:64]  == PosLimit) || (m_axis_tdata[95:64]  == NegLimit) ||
      (m_axis_tdata[127:96] == PosLimit) || (m_axis_tdata[127:96] == NegLimit))
    else $error("saturated flag without a clipped component");

endmodule

bind matrix_vector_transform_4x4_top mvt_checker u_mvt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
